### rtl/core/dfr_pkg.sv
// Shared constants and types for the gamepad frame deframer.
// Used by every module under rtl/core; depends on nothing else.
package dfr_pkg;

  localparam int unsigned FRAME_LEN   = 11;
  localparam int unsigned PAYLOAD_LEN = 8;
  localparam int unsigned IDX_CHK     = FRAME_LEN - 2;
  localparam int unsigned IDX_END     = FRAME_LEN - 1;
  localparam int unsigned IDX_W       = $clog2(FRAME_LEN);
  localparam int unsigned PL_IDX_W    = $clog2(PAYLOAD_LEN);

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W     = BYTE_W;

  localparam logic [BYTE_W-1:0] SYNC_RESET = 8'haf;
  localparam logic [BYTE_W-1:0] END_RESET  = 8'hed;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SYNC = 1'b0,
    CFG_END  = 1'b1
  } cfg_reg_e;

  // Frame bytes 1..8 in frame order.
  typedef struct packed {
    logic [BYTE_W-1:0] left_x;
    logic [BYTE_W-1:0] left_y;
    logic [BYTE_W-1:0] right_x;
    logic [BYTE_W-1:0] right_y;
    logic [BYTE_W-1:0] left_trigger;
    logic [BYTE_W-1:0] right_trigger;
    logic [BYTE_W-1:0] face_buttons;
    logic [BYTE_W-1:0] shoulder_buttons;
  } frame_t;

endpackage

### rtl/core/dfr_in_stage.sv
// Input register of the deframer: captures one received byte per item.
// Depends on dfr_pkg.
module dfr_in_stage (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [dfr_pkg::BYTE_W-1:0] rx_byte_i,
  input  logic                      advance_i,
  output logic                      valid_o,
  output logic [dfr_pkg::BYTE_W-1:0] byte_o
);
  import dfr_pkg::*;

  logic              valid_q, valid_d;
  logic [BYTE_W-1:0] byte_q;
  logic              load;

  // The register can take a new item when empty or when its item moves on.
  assign in_ready_o = !valid_q || advance_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= rx_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

### rtl/core/dfr_assembler.sv
// Frame assembler: tracks the position in the frame, keeps the payload bytes,
// a running checksum and the checksum byte, and flags a good frame.
// Depends on dfr_pkg.
module dfr_assembler (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic [dfr_pkg::BYTE_W-1:0] byte_i,
  input  logic [dfr_pkg::BYTE_W-1:0] sync_i,
  input  logic [dfr_pkg::BYTE_W-1:0] end_i,
  output logic                       hit_o,
  output dfr_pkg::frame_t            frame_o
);
  import dfr_pkg::*;

  logic                collecting_q, collecting_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [BYTE_W-1:0]   sum_q, sum_d;
  logic [BYTE_W-1:0]   chk_q;
  logic [BYTE_W-1:0]   store_q [PAYLOAD_LEN];
  logic                is_sync;
  logic                active;
  logic [IDX_W-1:0]    idx_cur;
  logic [IDX_W-1:0]    idx_off;
  logic [PL_IDX_W-1:0] wr_idx;
  logic                wr_payload;
  logic                wr_chk;
  logic                at_end;

  assign is_sync = (byte_i == sync_i);
  assign active  = step_i && (is_sync || collecting_q);
  // A sync byte always restarts the frame at byte 0.
  assign idx_cur = is_sync ? '0 : idx_q;
  assign at_end  = (idx_cur == IDX_W'(IDX_END));
  assign idx_off = idx_cur - IDX_W'(1);
  assign wr_idx  = idx_off[PL_IDX_W-1:0];

  assign wr_payload = active && (idx_cur != '0) && (idx_cur <= IDX_W'(PAYLOAD_LEN));
  assign wr_chk     = active && (idx_cur == IDX_W'(IDX_CHK));

  always_comb begin
    collecting_d = collecting_q;
    idx_d        = idx_q;
    sum_d        = sum_q;
    hit_o        = 1'b0;
    if (active) begin
      if (at_end) begin
        collecting_d = 1'b0;
        idx_d        = '0;
        hit_o        = (byte_i == end_i) && (sum_q == chk_q);
      end else begin
        collecting_d = 1'b1;
        idx_d        = idx_cur + IDX_W'(1);
      end
      if (idx_cur == '0) begin
        sum_d = '0;
      end else if (wr_payload) begin
        sum_d = sum_q + byte_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      collecting_q <= 1'b0;
      idx_q        <= '0;
    end else begin
      collecting_q <= collecting_d;
      idx_q        <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
    if (wr_payload) begin
      store_q[wr_idx] <= byte_i;
    end
    if (wr_chk) begin
      chk_q <= byte_i;
    end
  end

  assign frame_o.left_x           = store_q[0];
  assign frame_o.left_y           = store_q[1];
  assign frame_o.right_x          = store_q[2];
  assign frame_o.right_y          = store_q[3];
  assign frame_o.left_trigger     = store_q[4];
  assign frame_o.right_trigger    = store_q[5];
  assign frame_o.face_buttons     = store_q[6];
  assign frame_o.shoulder_buttons = store_q[7];

  a_idx_needs_frame : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idx_q != '0) |-> collecting_q)
    else $error("frame position set outside a frame");

  a_idx_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= IDX_W'(IDX_END))
    else $error("frame position past the last byte");

  a_hit_at_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_o |-> (step_i && collecting_q && (idx_q == IDX_W'(IDX_END)) && (byte_i == end_i)))
    else $error("frame accepted away from its end marker");

  a_end_closes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (active && at_end) |=> (!collecting_q && (idx_q == '0)))
    else $error("frame did not close after its last byte");

endmodule

### rtl/core/dfr_out_stage.sv
// Result register of the deframer: holds one decoded frame until taken.
// Depends on dfr_pkg.
module dfr_out_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  dfr_pkg::frame_t frame_i,
  output logic            can_load_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output dfr_pkg::frame_t frame_o
);
  import dfr_pkg::*;

  logic   valid_q, valid_d;
  frame_t frame_q;

  assign can_load_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      frame_q <= frame_i;
    end
  end

  assign out_valid_o = valid_q;
  assign frame_o     = frame_q;

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> can_load_o)
    else $error("result register overwritten before it was taken");

  a_valid_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("result dropped before it was taken");

  a_frame_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(frame_o))
    else $error("result changed while waiting to be taken");

endmodule

### rtl/core/gamepad_frame_deframer.sv
// Gamepad frame deframer: top level with configuration registers.
// Depends on dfr_pkg, dfr_in_stage, dfr_assembler and dfr_out_stage.
//
// Takes one serial byte per item and assembles 11-byte frames: a byte equal
// to the sync register starts a frame at any time, even inside a frame, and
// when byte 10 arrives the frame is checked (byte 10 must equal the end
// register, byte 9 must equal the 8-bit sum of bytes 1..8). A good frame
// gives one result carrying bytes 1..8; a bad frame or a stray byte gives
// none. The block takes one item every clock cycle while the input side is
// not stalled. A byte passes an input register and the frame logic, and the
// result of a good frame is then offered from the result register. The input
// side stalls only while both the input register and an untaken result are
// held. Configuration writes take effect on the next edge.
module gamepad_frame_deframer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dfr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [dfr_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [dfr_pkg::BYTE_W-1:0]    rx_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [dfr_pkg::BYTE_W-1:0]    left_x_o,
  output logic [dfr_pkg::BYTE_W-1:0]    left_y_o,
  output logic [dfr_pkg::BYTE_W-1:0]    right_x_o,
  output logic [dfr_pkg::BYTE_W-1:0]    right_y_o,
  output logic [dfr_pkg::BYTE_W-1:0]    left_trigger_o,
  output logic [dfr_pkg::BYTE_W-1:0]    right_trigger_o,
  output logic [dfr_pkg::BYTE_W-1:0]    face_buttons_o,
  output logic [dfr_pkg::BYTE_W-1:0]    shoulder_buttons_o
);
  import dfr_pkg::*;

  logic [BYTE_W-1:0] sync_q;
  logic [BYTE_W-1:0] end_q;
  logic              s1_valid;
  logic [BYTE_W-1:0] s1_byte;
  logic              advance;
  logic              can_load;
  logic              hit;
  frame_t            frame_asm;
  frame_t            frame_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q <= SYNC_RESET;
      end_q  <= END_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_SYNC: sync_q <= cfg_wdata_i[BYTE_W-1:0];
        CFG_END:  end_q  <= cfg_wdata_i[BYTE_W-1:0];
      endcase
    end
  end

  // An item leaves the input register only when the result register has room, whether or not it closes a good frame.
  assign advance = s1_valid && can_load;

  dfr_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .rx_byte_i  (rx_byte_i),
    .advance_i  (advance),
    .valid_o    (s1_valid),
    .byte_o     (s1_byte)
  );

  dfr_assembler u_asm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .byte_i  (s1_byte),
    .sync_i  (sync_q),
    .end_i   (end_q),
    .hit_o   (hit),
    .frame_o (frame_asm)
  );

  dfr_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (hit),
    .frame_i     (frame_asm),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .frame_o     (frame_out)
  );

  assign left_x_o           = frame_out.left_x;
  assign left_y_o           = frame_out.left_y;
  assign right_x_o          = frame_out.right_x;
  assign right_y_o          = frame_out.right_y;
  assign left_trigger_o     = frame_out.left_trigger;
  assign right_trigger_o    = frame_out.right_trigger;
  assign face_buttons_o     = frame_out.face_buttons;
  assign shoulder_buttons_o = frame_out.shoulder_buttons;

  a_hit_needs_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit |-> advance)
    else $error("frame result produced without an advancing item");

  a_stall_only_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid && out_valid_o && !out_ready_i))
    else $error("input stalled while the pipeline had room");

  a_result_follows_hit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit |=> out_valid_o)
    else $error("good frame did not reach the result register");

endmodule

### tb/tb_top.sv
// Self-checking testbench for gamepad_frame_deframer: random and directed serial bytes,
// an in-bench frame predictor and field-by-field result checks.
// Depends on dfr_pkg and the gamepad_frame_deframer RTL only.
module tb_top;
  import dfr_pkg::*;

  localparam int HOLD_CYCLES = 80;
  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 6;

  typedef enum int {FRAME_GOOD, FRAME_BAD_SUM, FRAME_BAD_END} frame_kind_e;
  typedef enum int {RDY_ALWAYS, RDY_RANDOM, RDY_PATTERN} ready_mode_e;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]  cfg_wdata_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [BYTE_W-1:0] rx_byte_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [BYTE_W-1:0] left_x_o, left_y_o, right_x_o, right_y_o;
  logic [BYTE_W-1:0] left_trigger_o, right_trigger_o, face_buttons_o, shoulder_buttons_o;

  gamepad_frame_deframer u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .rx_byte_i         (rx_byte_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .left_x_o          (left_x_o),
    .left_y_o          (left_y_o),
    .right_x_o         (right_x_o),
    .right_y_o         (right_y_o),
    .left_trigger_o    (left_trigger_o),
    .right_trigger_o   (right_trigger_o),
    .face_buttons_o    (face_buttons_o),
    .shoulder_buttons_o(shoulder_buttons_o)
  );

  always #1 clk_i = ~clk_i;

  // Predictor state, a private copy of the block's registers and frame buffer.
  logic [BYTE_W-1:0] sync_val = SYNC_RESET;
  logic [BYTE_W-1:0] end_val  = END_RESET;
  bit                in_frame = 1'b0;
  int                frame_pos = 0;
  logic [BYTE_W-1:0] frame_bytes [FRAME_LEN];

  logic [BYTE_W-1:0] pending_bytes [$];
  frame_t            frames_due [$];

  int err_count = 0;
  int bytes_taken = 0;
  int frames_checked = 0;
  int stall_cycles = 0;
  int settings_used = 1;
  int hold_requests = 0;

  task automatic deframe_byte(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] sum;
    int k;
    if (b == sync_val) begin
      in_frame = 1'b1;
      frame_pos = 0;
    end
    if (in_frame) begin
      frame_bytes[frame_pos] = b;
      frame_pos++;
      if (frame_pos == FRAME_LEN) begin
        in_frame = 1'b0;
        frame_pos = 0;
        sum = '0;
        for (k = 1; k <= PAYLOAD_LEN; k++) sum += frame_bytes[k];
        if (frame_bytes[IDX_END] == end_val && sum == frame_bytes[IDX_CHK]) begin
          frames_due.push_back({frame_bytes[1], frame_bytes[2], frame_bytes[3],
                                frame_bytes[4], frame_bytes[5], frame_bytes[6],
                                frame_bytes[7], frame_bytes[8]});
        end
      end
    end
  endtask

  // Driver: offers queued bytes in bursts separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        deframe_byte(rx_byte_i);
        bytes_taken++;
      end
      if (in_valid_i && !in_ready_o) stall_cycles++;
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          in_valid_i <= 1'b1;
          rx_byte_i <= pending_bytes.pop_front();
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 40);
            gap_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 25)
                                                   : $urandom_range(0, 4);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [BYTE_W-1:0] exp,
                             input logic [BYTE_W-1:0] act);
    if (act !== exp) begin
      $error("%s mismatch: expected %02h, got %02h", name, exp, act);
      err_count++;
    end
  endtask

  // Monitor: checks every taken result and drives the receiver's stall pattern.
  ready_mode_e ready_mode = RDY_ALWAYS;
  int mode_left = 0;
  int hold_left = 0;
  int holds_started = 0;
  int rx_cycle = 0;

  always @(posedge clk_i) begin
    frame_t exp;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        frames_checked++;
        if (frames_due.size() == 0) begin
          $error("result taken with no frame expected");
          err_count++;
        end else begin
          exp = frames_due.pop_front();
          check_field("left_x", exp.left_x, left_x_o);
          check_field("left_y", exp.left_y, left_y_o);
          check_field("right_x", exp.right_x, right_x_o);
          check_field("right_y", exp.right_y, right_y_o);
          check_field("left_trigger", exp.left_trigger, left_trigger_o);
          check_field("right_trigger", exp.right_trigger, right_trigger_o);
          check_field("face_buttons", exp.face_buttons, face_buttons_o);
          check_field("shoulder_buttons", exp.shoulder_buttons, shoulder_buttons_o);
        end
      end
      rx_cycle++;
      if (holds_started != hold_requests) begin
        holds_started = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          ready_mode = ready_mode_e'($urandom_range(0, 2));
          mode_left = $urandom_range(50, 300);
        end else begin
          mode_left--;
        end
        case (ready_mode)
          RDY_ALWAYS: out_ready_i <= 1'b1;
          RDY_RANDOM: out_ready_i <= ($urandom_range(0, 2) != 0);
          default:    out_ready_i <= ((rx_cycle % 7) >= 3);
        endcase
      end
    end
  end

  // Watchdog: ends the run when neither side has moved an item for too long.
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("gamepad_frame_deframer verification failed");
      $finish;
    end
  end

  task automatic cfg_write(input cfg_reg_e idx, input logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    if (idx == CFG_SYNC) sync_val = val;
    else end_val = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_regs(input logic [BYTE_W-1:0] sync_b, input logic [BYTE_W-1:0] end_b);
    cfg_write(CFG_SYNC, sync_b);
    cfg_write(CFG_END, end_b);
    settings_used++;
  endtask

  // Wait until every byte is taken and every frame has come back, then let the
  // pipeline settle, since a byte that closes a bad frame leaves no trace.
  task automatic drain();
    @(negedge clk_i);
    while (pending_bytes.size() != 0 || in_valid_i || frames_due.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [BYTE_W-1:0] any_but_sync();
    logic [BYTE_W-1:0] v;
    do v = $urandom_range(0, 255); while (v == sync_val);
    return v;
  endfunction

  function automatic logic [BYTE_W-1:0] payload_sum(input logic [BYTE_W-1:0] pl [PAYLOAD_LEN]);
    logic [BYTE_W-1:0] sum;
    sum = '0;
    foreach (pl[k]) sum += pl[k];
    return sum;
  endfunction

  task automatic queue_frame(input logic [BYTE_W-1:0] pl [PAYLOAD_LEN],
                             input frame_kind_e kind);
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] chk;
    logic [BYTE_W-1:0] tail;
    sum = payload_sum(pl);
    chk = sum;
    tail = end_val;
    if (kind == FRAME_BAD_SUM) begin
      do chk = $urandom_range(0, 255); while (chk == sum || chk == sync_val);
    end
    if (kind == FRAME_BAD_END) begin
      do tail = $urandom_range(0, 255); while (tail == end_val || tail == sync_val);
    end
    pending_bytes.push_back(sync_val);
    foreach (pl[k]) pending_bytes.push_back(pl[k]);
    pending_bytes.push_back(chk);
    pending_bytes.push_back(tail);
  endtask

  // Mostly well-formed frames with random content; the rest are corrupted,
  // cut short by a new sync byte, or plain line noise.
  task automatic random_traffic(input int n_bytes);
    logic [BYTE_W-1:0] pl [PAYLOAD_LEN];
    int start;
    int pick;
    int k;
    int n;
    @(negedge clk_i);
    start = pending_bytes.size();
    while (pending_bytes.size() - start < n_bytes) begin
      pick = $urandom_range(0, 99);
      if (pick < 86) begin
        do begin
          foreach (pl[j]) pl[j] = any_but_sync();
        end while (payload_sum(pl) == sync_val);
        queue_frame(pl, (pick < 68) ? FRAME_GOOD : (pick < 78) ? FRAME_BAD_SUM : FRAME_BAD_END);
      end else if (pick < 94) begin
        n = $urandom_range(0, 9);
        pending_bytes.push_back(sync_val);
        for (k = 0; k < n; k++) pending_bytes.push_back(any_but_sync());
      end else begin
        n = $urandom_range(1, 5);
        for (k = 0; k < n; k++) pending_bytes.push_back($urandom_range(0, 255));
      end
    end
  endtask

  initial begin
    logic [BYTE_W-1:0] rand_sync;
    logic [BYTE_W-1:0] rand_end;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: stray bytes before any frame, a frame cut short by a new sync
    // byte, a good frame with extreme payload values, then a bad end marker.
    pending_bytes.push_back(8'h00);
    pending_bytes.push_back(8'hff);
    pending_bytes.push_back(sync_val);
    pending_bytes.push_back(8'h12);
    pending_bytes.push_back(8'h34);
    queue_frame('{8'h00, 8'hff, 8'h01, 8'h80, 8'h7f, 8'hfe, 8'haa, 8'h55}, FRAME_GOOD);
    queue_frame('{8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff}, FRAME_BAD_END);
    drain();

    random_traffic(150);
    drain();

    // The receiver holds off while the sender keeps offering frames.
    set_regs(8'h00, 8'hff);
    @(negedge clk_i);
    hold_requests++;
    random_traffic(220);
    drain();

    set_regs(8'hff, 8'h00);
    random_traffic(170);
    drain();

    // With the end marker equal to the sync byte no frame can ever pass.
    set_regs(8'h5a, 8'h5a);
    random_traffic(60);
    drain();

    rand_sync = $urandom_range(0, 255);
    do rand_end = $urandom_range(0, 255); while (rand_end == rand_sync);
    set_regs(rand_sync, rand_end);
    @(negedge clk_i);
    hold_requests++;
    random_traffic(270);
    drain();

    $display("Run covered %0d serial bytes under %0d register settings.",
             bytes_taken, settings_used);
    $display("%0d frames checked; input stalled for %0d cycles.",
             frames_checked, stall_cycles);
    if (err_count == 0) begin
      $display("gamepad_frame_deframer verification clean");
    end else begin
      $display("gamepad_frame_deframer verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/dfr_pkg.sv
rtl/core/dfr_in_stage.sv
rtl/core/dfr_assembler.sv
rtl/core/dfr_out_stage.sv
rtl/core/gamepad_frame_deframer.sv
tb/tb_top.sv
